>>> rtl/qlhc_pkg.sv
// Shared types and constants for the QUIC long-header classifier.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package qlhc_pkg;

    // Datagram byte index limit; the position saturates here
    localparam int unsigned MAX_DATAGRAM_BYTES = 65535;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned LIST_W     = POS_W + 1;
    localparam int unsigned TALLY_W    = 14;
    localparam int unsigned WORD_W     = 32;

    // Header layout
    localparam logic [7:0] LONG_HDR_BIT  = 8'h80;
    localparam logic [7:0] TYPE_MASK     = 8'h30;
    localparam int unsigned TYPE_SHIFT   = 4;
    localparam int unsigned MIN_HDR_POS  = 6;   // index of the final byte of a 7-byte header
    localparam int unsigned DCID_LEN_POS = 5;
    localparam int unsigned VER_LAST_POS = 4;

    // Result queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;

    // Output packing
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned M_TUSER_W = 3;

    typedef enum logic [2:0] {
        KIND_SHORT     = 3'd0,
        KIND_UNKNOWN   = 3'd1,
        KIND_VERSION_NEG = 3'd2,
        KIND_INITIAL   = 3'd3,
        KIND_ZERO_RTT  = 3'd4,
        KIND_HANDSHAKE = 3'd5,
        KIND_RETRY     = 3'd6
    } kind_t;

    // One queue entry: everything a single byte produced
    typedef struct packed {
        logic                 has_word;
        logic                 has_sum;
        kind_t                kind;
        logic [WORD_W-1:0]    version;
        logic [WORD_W-1:0]    offered;
        logic [TALLY_W-1:0]   count;
        logic                 token;
    } event_t;

endpackage

`default_nettype wire

>>> rtl/quic_long_header_classifier.sv
// Top level of the QUIC long-header classifier: front parser, event queue, back emitter.
// Depends on qlhc_pkg, qlhc_front, qlhc_queue and qlhc_back.
//
//  Channel | Dir | Handshake          | Payload
//  s_      | in  | s_tvalid/s_tready  | tdata = data_byte, tlast = end_of_datagram
//  m_      | out | m_tvalid/m_tready  | tdata = version/offered/count/token, tuser = kind,
//          |     |                    | tlast = is_summary
//
// One byte is taken per cycle unless the queue is full, and is parsed in that cycle.
// A result reaches m_ by way of the queue: the event is written into it when its byte
// is accepted and then loaded into the output register. A byte that ends a datagram
// with a completed offered word gives two results, the offered word before the summary.
// The four-entry event queue sets how far the input may run ahead of a stalled output;
// s_tready falls only when it is full. Reset is synchronous; no clearing pass is needed.
`default_nettype none

module quic_long_header_classifier (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_datagram
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [31:0] packet_version, [63:32] offered_version,
                                        // [77:64] offered_count, [78] token_issued, [79] zero
    output logic [2:0]       m_tuser,   // [2:0] packet_kind
    output logic             m_tlast    // is_summary
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    qlhc_pkg::event_t push_ev;
    qlhc_pkg::event_t head_ev;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    qlhc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .data_byte       (s_tdata),
        .end_of_datagram (s_tlast),
        .push            (push),
        .ev              (push_ev)
    );

    qlhc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_ev (push_ev),
        .pop     (pop),
        .head_ev (head_ev),
        .empty   (q_empty),
        .full    (q_full)
    );

    qlhc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_ev  (head_ev),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/qlhc_front.sv
// Front part: per-byte header parsing and classification.
// Depends on qlhc_pkg; produces one event per byte that yields a word or a summary.
`default_nettype none

module qlhc_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 end_of_datagram,
    output logic                      push,
    output qlhc_pkg::event_t          ev
);

    logic [qlhc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                   first_reg, first_next;
    logic [qlhc_pkg::WORD_W-1:0]  ver_reg, ver_next;
    logic [qlhc_pkg::POS_W-1:0]   sli_reg, sli_next;
    logic [qlhc_pkg::LIST_W-1:0]  lsi_reg, lsi_next;
    logic                         seen_reg, seen_next;
    logic [qlhc_pkg::WORD_W-1:0]  wacc_reg, wacc_next;
    logic [1:0]                   fill_reg, fill_next;
    logic [qlhc_pkg::TALLY_W-1:0] tally_reg, tally_next;

    logic                         word_out;
    logic [1:0]                   type_bits;
    qlhc_pkg::kind_t              typed_kind;

    // Byte parsing: updated state after this byte
    always_comb begin
        first_next = first_reg;
        ver_next   = ver_reg;
        sli_next   = sli_reg;
        lsi_next   = lsi_reg;
        seen_next  = seen_reg;
        wacc_next  = wacc_reg;
        fill_next  = fill_reg;
        tally_next = tally_reg;
        word_out   = 1'b0;
        priority if (pos_reg == '0) begin
            first_next = data_byte;
        end else if (pos_reg <= qlhc_pkg::POS_W'(qlhc_pkg::VER_LAST_POS)) begin
            ver_next = {ver_reg[qlhc_pkg::WORD_W-9:0], data_byte};
        end else if (pos_reg == qlhc_pkg::POS_W'(qlhc_pkg::DCID_LEN_POS)) begin
            sli_next = qlhc_pkg::POS_W'(qlhc_pkg::MIN_HDR_POS) + {8'd0, data_byte};
        end else if (!seen_reg && pos_reg == sli_reg) begin
            seen_next = 1'b1;
            lsi_next  = {1'b0, pos_reg} + qlhc_pkg::LIST_W'(1) + {9'd0, data_byte};
        end else if (seen_reg && ({1'b0, pos_reg} >= lsi_reg) &&
                     ((first_reg & qlhc_pkg::LONG_HDR_BIT) != 8'd0) && ver_reg == '0) begin
            wacc_next = {wacc_reg[qlhc_pkg::WORD_W-9:0], data_byte};
            if (fill_reg == 2'd3) begin
                fill_next = 2'd0;
                word_out  = 1'b1;
                if (tally_reg != '1) begin
                    tally_next = tally_reg + qlhc_pkg::TALLY_W'(1);
                end
            end else begin
                fill_next = fill_reg + 2'd1;
            end
        end else begin
            // leftover byte: ignored
        end
    end

    // Type bits to kind
    always_comb begin
        type_bits = 2'((first_next & qlhc_pkg::TYPE_MASK) >> qlhc_pkg::TYPE_SHIFT);
        unique case (type_bits)
            2'd0: typed_kind = qlhc_pkg::KIND_INITIAL;
            2'd1: typed_kind = qlhc_pkg::KIND_ZERO_RTT;
            2'd2: typed_kind = qlhc_pkg::KIND_HANDSHAKE;
            2'd3: typed_kind = qlhc_pkg::KIND_RETRY;
        endcase
    end

    // Event contents; a word and a summary of the same byte share the count
    always_comb begin
        ev.has_word = word_out;
        ev.has_sum  = end_of_datagram;
        ev.offered  = wacc_next;
        ev.count    = '0;
        ev.version  = '0;
        ev.token    = 1'b0;
        ev.kind     = qlhc_pkg::KIND_VERSION_NEG;
        if (word_out) begin
            ev.count = tally_next;
        end
        priority if ((first_next & qlhc_pkg::LONG_HDR_BIT) == 8'd0) begin
            ev.kind = qlhc_pkg::KIND_SHORT;
        end else if (pos_reg < qlhc_pkg::POS_W'(qlhc_pkg::MIN_HDR_POS)) begin
            ev.kind = qlhc_pkg::KIND_UNKNOWN;
        end else if (!seen_next) begin
            ev.kind    = qlhc_pkg::KIND_UNKNOWN;
            ev.version = ver_next;
        end else if (ver_next == '0) begin
            ev.kind  = qlhc_pkg::KIND_VERSION_NEG;
            ev.count = tally_next;
        end else begin
            ev.kind    = typed_kind;
            ev.version = ver_next;
            ev.token   = (typed_kind == qlhc_pkg::KIND_RETRY);
        end
    end

    assign push = accept && (word_out || end_of_datagram);

    // Position advance, saturating
    always_comb begin
        pos_next = pos_reg;
        if (pos_reg < qlhc_pkg::POS_W'(qlhc_pkg::MAX_DATAGRAM_BYTES)) begin
            pos_next = pos_reg + qlhc_pkg::POS_W'(1);
        end
    end

    // State registers; cleared at reset and at every datagram end
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && end_of_datagram)) begin
            pos_reg   <= '0;
            first_reg <= '0;
            ver_reg   <= '0;
            sli_reg   <= '0;
            lsi_reg   <= '0;
            seen_reg  <= 1'b0;
            wacc_reg  <= '0;
            fill_reg  <= '0;
            tally_reg <= '0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
            ver_reg   <= ver_next;
            sli_reg   <= sli_next;
            lsi_reg   <= lsi_next;
            seen_reg  <= seen_next;
            wacc_reg  <= wacc_next;
            fill_reg  <= fill_next;
            tally_reg <= tally_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/qlhc_queue.sv
// Short event queue between the parsing front and the output back.
// Depends on qlhc_pkg for the entry type and depth.
`default_nettype none

module qlhc_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire qlhc_pkg::event_t  push_ev,
    input  wire logic              pop,
    output qlhc_pkg::event_t       head_ev,
    output logic                   empty,
    output logic                   full
);

    qlhc_pkg::event_t                 entry_reg [qlhc_pkg::QUEUE_DEPTH];
    logic [qlhc_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [qlhc_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [qlhc_pkg::QUEUE_CW-1:0]    cnt_reg, cnt_next;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == qlhc_pkg::QUEUE_CW'(qlhc_pkg::QUEUE_DEPTH));
    assign head_ev = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + qlhc_pkg::QUEUE_AW'(push);
        rd_ptr_next = rd_ptr_reg + qlhc_pkg::QUEUE_AW'(pop);
        cnt_next    = cnt_reg + qlhc_pkg::QUEUE_CW'(push) - qlhc_pkg::QUEUE_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_ev;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= qlhc_pkg::QUEUE_CW'(qlhc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/qlhc_back.sv
// Back part: takes queued events and presents their results, word before summary.
// Depends on qlhc_pkg; the held event doubles as the output register.
`default_nettype none

module qlhc_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire qlhc_pkg::event_t                   head_ev,
    input  wire logic                               empty,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [qlhc_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [qlhc_pkg::M_TUSER_W-1:0]          m_tuser,
    output logic                                    m_tlast
);

    qlhc_pkg::event_t ev_reg;
    logic             word_left_reg, word_left_next;
    logic             sum_left_reg, sum_left_next;
    logic             xfer;
    logic             done;

    assign m_tvalid = word_left_reg || sum_left_reg;
    assign xfer     = m_tvalid && m_tready;

    // What remains of the held event after this cycle
    always_comb begin
        word_left_next = word_left_reg && !xfer;
        sum_left_next  = sum_left_reg && !(xfer && !word_left_reg);
        done           = !word_left_next && !sum_left_next;
        pop            = !empty && done;
        if (pop) begin
            word_left_next = head_ev.has_word;
            sum_left_next  = head_ev.has_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_left_reg <= 1'b0;
            sum_left_reg  <= 1'b0;
        end else begin
            word_left_reg <= word_left_next;
            sum_left_reg  <= sum_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ev_reg <= head_ev;
        end
    end

    // Output select: offered word first, then the summary
    always_comb begin
        m_tdata = '0;
        m_tdata[qlhc_pkg::WORD_W+qlhc_pkg::WORD_W +: qlhc_pkg::TALLY_W] = ev_reg.count;
        if (word_left_reg) begin
            m_tlast = 1'b0;
            m_tuser = qlhc_pkg::M_TUSER_W'(qlhc_pkg::KIND_VERSION_NEG);
            m_tdata[qlhc_pkg::WORD_W +: qlhc_pkg::WORD_W] = ev_reg.offered;
        end else begin
            m_tlast = 1'b1;
            m_tuser = qlhc_pkg::M_TUSER_W'(ev_reg.kind);
            m_tdata[0 +: qlhc_pkg::WORD_W] = ev_reg.version;
            m_tdata[2*qlhc_pkg::WORD_W+qlhc_pkg::TALLY_W] = ev_reg.token;
        end
    end

    a_word_is_vn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == qlhc_pkg::M_TUSER_W'(qlhc_pkg::KIND_VERSION_NEG))
        else $error("offered word with a kind other than version negotiation");
    a_token_retry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*qlhc_pkg::WORD_W+qlhc_pkg::TALLY_W]
        |-> m_tlast && m_tuser == qlhc_pkg::M_TUSER_W'(qlhc_pkg::KIND_RETRY))
        else $error("token flag outside a Retry summary");
    a_word_then_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && word_left_reg && sum_left_reg |=> m_tvalid && m_tlast)
        else $error("summary lost after its offered word");

endmodule

`default_nettype wire

>>> tb/quic_long_header_classifier_tb.sv
// Self-checking testbench for quic_long_header_classifier: streams datagrams byte by byte,
// predicts offered-version words and datagram summaries, and checks every m_ transfer.
// Depends on qlhc_pkg and the RTL under rtl/.

module quic_long_header_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTED  = 100;
    localparam int PHASE_BYTES  = 335;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dgram_byte_t;

    typedef struct packed {
        logic             is_summary;
        qlhc_pkg::kind_t  kind;
        logic [31:0]      version;
        logic [31:0]      offered;
        logic [13:0]      count;
        logic             token;
    } classify_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    quic_long_header_classifier i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    dgram_byte_t      pending_bytes[$];
    logic [7:0]       frame[$];
    classify_result_t expected_results[$];
    int               bytes_queued   = 0;
    int               bytes_accepted = 0;
    int               error_count    = 0;
    int               send_idle_pct  = 0;
    int               recv_idle_pct  = 0;
    int               stall_cycles   = 0;
    dgram_byte_t      next_byte;

    // Parser state mirror
    logic [15:0] pos;
    logic [7:0]  first_byte;
    logic [31:0] hdr_version;
    logic [15:0] scid_len_pos;
    logic [16:0] list_start;
    logic        scid_len_seen;
    logic [31:0] word_acc;
    logic [1:0]  word_fill;
    logic [13:0] offer_tally;

    task automatic clear_parser();
        pos           = '0;
        first_byte    = '0;
        hdr_version   = '0;
        scid_len_pos  = '0;
        list_start    = '0;
        scid_len_seen = 1'b0;
        word_acc      = '0;
        word_fill     = '0;
        offer_tally   = '0;
    endtask

    function automatic classify_result_t make_result(logic summ, qlhc_pkg::kind_t kind,
            logic [31:0] ver, logic [31:0] offered, logic [13:0] count, logic tok);
        classify_result_t r;
        r.is_summary = summ;
        r.kind       = kind;
        r.version    = ver;
        r.offered    = offered;
        r.count      = count;
        r.token      = tok;
        return r;
    endfunction

    task automatic expect_result(input classify_result_t r);
        expected_results = {expected_results, r};
    endtask

    // Advance the parser by one accepted byte, queueing what it produces
    task automatic classify_byte(input logic [7:0] b, input logic last);
        logic [1:0] ptype;
        if (pos == 0) begin
            first_byte = b;
        end else if (pos <= qlhc_pkg::VER_LAST_POS) begin
            hdr_version = {hdr_version[23:0], b};
        end else if (pos == qlhc_pkg::DCID_LEN_POS) begin
            scid_len_pos = 16'd6 + b;
        end else if (!scid_len_seen && pos == scid_len_pos) begin
            scid_len_seen = 1'b1;
            list_start    = pos + 17'd1 + b;
        end else if (scid_len_seen && {1'b0, pos} >= list_start
                     && (first_byte & qlhc_pkg::LONG_HDR_BIT) != 0 && hdr_version == 0) begin
            word_acc = {word_acc[23:0], b};
            if (word_fill == 2'd3) begin
                word_fill = '0;
                if (offer_tally != '1)
                    offer_tally++;
                expect_result(make_result(1'b0, qlhc_pkg::KIND_VERSION_NEG, '0,
                                          word_acc, offer_tally, 1'b0));
            end else begin
                word_fill++;
            end
        end

        if (last) begin
            ptype = 2'((first_byte & qlhc_pkg::TYPE_MASK) >> qlhc_pkg::TYPE_SHIFT);
            if ((first_byte & qlhc_pkg::LONG_HDR_BIT) == 0)
                expect_result(make_result(1'b1, qlhc_pkg::KIND_SHORT, '0, '0, '0, 1'b0));
            else if (pos < qlhc_pkg::MIN_HDR_POS)
                expect_result(make_result(1'b1, qlhc_pkg::KIND_UNKNOWN, '0, '0, '0, 1'b0));
            else if (!scid_len_seen)
                expect_result(make_result(1'b1, qlhc_pkg::KIND_UNKNOWN, hdr_version,
                                          '0, '0, 1'b0));
            else if (hdr_version == 0)
                expect_result(make_result(1'b1, qlhc_pkg::KIND_VERSION_NEG, '0, '0,
                                          offer_tally, 1'b0));
            else
                expect_result(make_result(1'b1,
                                          qlhc_pkg::kind_t'(qlhc_pkg::KIND_INITIAL + ptype),
                                          hdr_version, '0, '0, ptype == 2'd3));
            clear_parser();
        end else if (pos < qlhc_pkg::MAX_DATAGRAM_BYTES) begin
            pos++;
        end
    endtask

    task automatic report(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // Input side: feeds pending bytes, predicts each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                classify_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.data;
                    s_tlast  <= next_byte.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output side: compare each transfer with the oldest prediction
    always @(posedge aclk) begin
        classify_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result kind=%0d tdata=%h", m_tuser, m_tdata));
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tlast !== exp_r.is_summary)
                    report($sformatf("is_summary %b, expected %b", m_tlast, exp_r.is_summary));
                if (m_tuser !== exp_r.kind)
                    report($sformatf("packet_kind %0d, expected %0d", m_tuser, exp_r.kind));
                if (m_tdata[31:0] !== exp_r.version)
                    report($sformatf("packet_version %h, expected %h",
                                     m_tdata[31:0], exp_r.version));
                if (m_tdata[63:32] !== exp_r.offered)
                    report($sformatf("offered_version %h, expected %h",
                                     m_tdata[63:32], exp_r.offered));
                if (m_tdata[77:64] !== exp_r.count)
                    report($sformatf("offered_count %0d, expected %0d",
                                     m_tdata[77:64], exp_r.count));
                if (m_tdata[78] !== exp_r.token)
                    report($sformatf("token_issued %b, expected %b", m_tdata[78], exp_r.token));
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("quic_long_header_classifier test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Move the built frame into the pending queue, marking its final byte
    task automatic flush_frame();
        dgram_byte_t item;
        for (int i = 0; i < frame.size(); i++) begin
            item.data = frame[i];
            item.last = (i == frame.size() - 1);
            pending_bytes = {pending_bytes, item};
            bytes_queued++;
        end
        frame.delete();
    endtask

    task automatic add_byte(input logic [7:0] b);
        frame = {frame, b};
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    // Mostly short IDs, now and then anything up to the full byte
    function automatic logic [7:0] pick_id_len();
        if ($urandom_range(99) < 95)
            return 8'($urandom_range(20));
        return 8'($urandom_range(255));
    endfunction

    // First byte, version, both connection IDs with their length bytes
    task automatic add_long_header(input logic [7:0] first, input logic [31:0] ver);
        logic [7:0] dlen;
        logic [7:0] slen;
        dlen = pick_id_len();
        slen = pick_id_len();
        add_byte(first | qlhc_pkg::LONG_HDR_BIT);
        for (int i = 3; i >= 0; i--)
            add_byte(ver[8*i +: 8]);
        add_byte(dlen);
        add_random_bytes(dlen);
        add_byte(slen);
        add_random_bytes(slen);
    endtask

    task automatic add_random_datagram();
        int          sel;
        logic [7:0]  dlen;
        logic [31:0] ver;
        sel = $urandom_range(99);
        if (sel < 10) begin
            // short header
            add_byte(8'($urandom_range(127)));
            add_random_bytes($urandom_range(11));
        end else if (sel < 20) begin
            // truncated long header
            add_byte(8'($urandom) | qlhc_pkg::LONG_HDR_BIT);
            add_random_bytes($urandom_range(5));
        end else if (sel < 30) begin
            // ends inside the destination ID, or on the source-ID length byte
            dlen = pick_id_len();
            ver  = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
            add_byte(8'($urandom) | qlhc_pkg::LONG_HDR_BIT);
            for (int i = 3; i >= 0; i--)
                add_byte(ver[8*i +: 8]);
            add_byte(dlen);
            add_random_bytes($urandom_range(dlen + 1, 1));
        end else if (sel < 62) begin
            // version negotiation with a list and maybe a partial word
            add_long_header(8'($urandom), 32'h0);
            add_random_bytes(4 * $urandom_range(6) + $urandom_range(3));
        end else if (sel < 92) begin
            // typed long header with payload
            ver = $urandom;
            if (ver == 0)
                ver = 32'h0000_0001;
            add_long_header(8'($urandom), ver);
            add_random_bytes($urandom_range(10));
        end else begin
            // noise
            add_random_bytes($urandom_range(20, 1));
        end
        flush_frame();
    endtask

    task automatic add_random_phase(input int budget);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            add_random_datagram();
    endtask

    task automatic wait_all_accepted();
        while (bytes_accepted != bytes_queued)
            @(posedge aclk);
    endtask

    // Stimulus and end of run
    initial begin
        clear_parser();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 69;

        // single-byte short header, all zeros
        add_byte(8'h00);
        flush_frame();
        // truncated: six bytes, all ones
        repeat (6) add_byte(8'hFF);
        flush_frame();
        // minimal Initial, empty IDs
        frame = '{8'hC0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        flush_frame();
        // version negotiation whose last byte completes a word
        frame = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF};
        flush_frame();

        add_random_phase(PHASE_BYTES);
        wait_all_accepted();

        send_idle_pct = 69;
        recv_idle_pct = 38;
        add_random_phase(PHASE_BYTES);
        wait_all_accepted();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_phase(PHASE_BYTES);
        wait_all_accepted();

        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("quic_long_header_classifier test passed");
        end else begin
            $display("quic_long_header_classifier test failed");
        end
        $finish;
    end

endmodule

>>> quic_long_header_classifier.f
rtl/qlhc_pkg.sv
rtl/qlhc_front.sv
rtl/qlhc_queue.sv
rtl/qlhc_back.sv
rtl/quic_long_header_classifier.sv
tb/quic_long_header_classifier_tb.sv
